>>> rtl/tmt_pkg.sv
// Shared types, constants and helpers for the text-mode terminal.
// No dependencies; every other file imports this package.
package tmt_pkg;

    localparam int MAX_ROWS  = 32;
    localparam int MAX_COLS  = 128;
    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int ROWS_W    = 6;
    localparam int COLS_W    = 8;
    localparam int CELL_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int TAB_W     = 3;

    localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(25);
    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(80);
    localparam logic [3:0]        FG_RESET   = 4'hF;
    localparam logic [3:0]        BG_RESET   = 4'h0;
    localparam logic [ROWS_W-1:0] ROWS_MAX   = ROWS_W'(MAX_ROWS);
    localparam logic [COLS_W-1:0] COLS_MAX   = COLS_W'(MAX_COLS);

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FG   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BG   = 2'd3;

    localparam logic [2:0] ACT_PUT_CHAR = 3'd0;
    localparam logic [2:0] ACT_SET_CUR  = 3'd1;
    localparam logic [2:0] ACT_DRAW_AT  = 3'd2;
    localparam logic [2:0] ACT_CLS      = 3'd3;
    localparam logic [2:0] ACT_CLR_LINE = 3'd4;
    localparam logic [2:0] ACT_READ     = 3'd5;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_NEWLINE,
        CMD_CR,
        CMD_TAB,
        CMD_BS,
        CMD_PRINT,
        CMD_SET_CUR,
        CMD_DRAW,
        CMD_CLS,
        CMD_CLR_LINE,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         ch;
        logic [3:0]         fg;
        logic [3:0]         bg;
        logic [ADDR_W-1:0]  addr;
        logic               hit;
        logic [ROW_W-1:0]   set_row;
        logic [COL_W-1:0]   set_col;
    } cmd_t;

    typedef struct packed {
        logic [ROWS_W-1:0]  rows;
        logic [COLS_W-1:0]  cols;
        logic [CNT_W-1:0]   cells;
        logic [ADDR_W-1:0]  last_base;
        logic [3:0]         fg;
        logic [3:0]         bg;
    } term_cfg_t;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_EXEC,
        ST_PRINT,
        ST_NEXTLINE,
        ST_COPY,
        ST_FILL,
        ST_READ,
        ST_DONE
    } back_state_t;

    function automatic logic [CELL_W-1:0] make_cell(logic [7:0] ch, logic [3:0] fg,
                                                   logic [3:0] bg);
        return {bg, fg, ch};
    endfunction

endpackage

>>> rtl/tmt_ifs.sv
// Handshake channels of the terminal: request, response and register write.
// Depends on tmt_pkg for field widths.
interface tmt_req_if import tmt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       action;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] target_row;
    logic [COL_W-1:0] target_col;
    logic [3:0]       cell_fg;
    logic [3:0]       cell_bg;

    modport source (output valid, action, char_code, target_row, target_col, cell_fg,
                    cell_bg, input ready);
    modport sink (input valid, action, char_code, target_row, target_col, cell_fg,
                  cell_bg, output ready);
endinterface

interface tmt_rsp_if import tmt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [CELL_W-1:0] cell_value;

    modport source (output valid, cur_row, cur_col, cell_value, input ready);
    modport sink (input valid, cur_row, cur_col, cell_value, output ready);
endinterface

interface tmt_cfg_if import tmt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/tmt_front.sv
// Request decoder: classifies each word into a back-end command.
// Depends on tmt_pkg and tmt_req_if.
module tmt_front import tmt_pkg::*;
(
    tmt_req_if.sink          req,
    input  term_cfg_t        geom,
    input  logic             wiping,
    input  logic             q_full,
    output logic             q_push,
    output cmd_t             q_data
);

    logic [CNT_W-1:0] row_base;
    logic             row_ok;
    logic             col_ok;

    assign req.ready = !q_full && !wiping;
    assign q_push    = req.valid && req.ready;

    assign row_base = CNT_W'(req.target_row) * CNT_W'(geom.cols);
    assign row_ok   = ROWS_W'(req.target_row) < geom.rows;
    assign col_ok   = COLS_W'(req.target_col) < geom.cols;

    always_comb
    begin
        q_data         = '0;
        q_data.kind    = CMD_NOP;
        q_data.ch      = req.char_code;
        q_data.fg      = req.cell_fg;
        q_data.bg      = req.cell_bg;
        q_data.addr    = ADDR_W'(row_base + CNT_W'(req.target_col));
        q_data.hit     = row_ok && col_ok;
        q_data.set_row = row_ok ? req.target_row : ROW_W'(geom.rows - 1'b1);
        q_data.set_col = col_ok ? req.target_col : COL_W'(geom.cols - 1'b1);
        case (req.action)
            ACT_PUT_CHAR:
            begin
                if (req.char_code == CH_LF)
                    q_data.kind = CMD_NEWLINE;
                else if (req.char_code == CH_CR)
                    q_data.kind = CMD_CR;
                else if (req.char_code == CH_TAB)
                    q_data.kind = CMD_TAB;
                else if (req.char_code == CH_BS)
                    q_data.kind = CMD_BS;
                else if (req.char_code >= CH_SPACE)
                    q_data.kind = CMD_PRINT;
            end
            ACT_SET_CUR:  q_data.kind = CMD_SET_CUR;
            ACT_DRAW_AT:  q_data.kind = CMD_DRAW;
            ACT_CLS:      q_data.kind = CMD_CLS;
            ACT_CLR_LINE:
            begin
                q_data.kind = CMD_CLR_LINE;
                q_data.addr = ADDR_W'(row_base);
                q_data.hit  = row_ok;
            end
            ACT_READ:     q_data.kind = CMD_READ;
            default:      q_data.kind = CMD_NOP;
        endcase
    end

endmodule

>>> rtl/tmt_queue.sv
// Two-entry command queue between decoder and executor.
// Depends on tmt_pkg.
module tmt_queue import tmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/tmt_back.sv
// Command executor: owns the screen memory, cursor and response register.
// Depends on tmt_pkg and tmt_rsp_if.
module tmt_back import tmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  term_cfg_t  geom,
    input  logic       q_empty,
    input  cmd_t       q_data,
    output logic       q_pop,
    output logic       wiping,
    tmt_rsp_if.source  rsp
);

    logic [CELL_W-1:0] mem [MEM_DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [TAB_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        pch_reg, pch_next;
    logic [CELL_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]  fill_addr_reg, fill_addr_next;
    logic [CNT_W-1:0]  fill_end_reg, fill_end_next;
    logic [CNT_W-1:0]  cp_addr_reg, cp_addr_next;
    logic              cp_pend_reg, cp_pend_next;
    logic [ADDR_W-1:0] cp_dst_reg, cp_dst_next;
    logic              out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [CELL_W-1:0] out_value_reg, out_value_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [CNT_W-1:0]  cur_addr;
    logic [CELL_W-1:0] blank;
    logic [COLS_W-1:0] col_inc;

    assign cur_addr = CNT_W'(row_reg) * CNT_W'(geom.cols) + CNT_W'(col_reg);
    assign blank    = make_cell(CH_SPACE, geom.fg, geom.bg);
    assign col_inc  = COLS_W'(col_reg) + 1'b1;

    assign wiping         = state_reg == ST_WIPE;
    assign rsp.valid      = out_valid_reg;
    assign rsp.cur_row    = out_row_reg;
    assign rsp.cur_col    = out_col_reg;
    assign rsp.cell_value = out_value_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        pch_next       = pch_reg;
        value_next     = value_reg;
        fill_addr_next = fill_addr_reg;
        fill_end_next  = fill_end_reg;
        cp_addr_next   = cp_addr_reg;
        cp_pend_next   = cp_pend_reg;
        cp_dst_next    = cp_dst_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_value_next = out_value_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cur_addr[ADDR_W-1:0];
        mem_wdata      = blank;
        mem_re         = 1'b0;
        mem_raddr      = cmd_reg.addr;

        case (state_reg)
            ST_WIPE:
            begin
                mem_we         = 1'b1;
                mem_waddr      = fill_addr_reg[ADDR_W-1:0];
                mem_wdata      = '0;
                fill_addr_next = fill_addr_reg + 1'b1;
                if (fill_addr_reg == CNT_W'(MEM_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    cnt_next   = '0;
                    value_next = '0;
                    if (ROWS_W'(row_reg) >= geom.rows)
                        row_next = ROW_W'(geom.rows - 1'b1);
                    if (COLS_W'(col_reg) >= geom.cols)
                        col_next = COL_W'(geom.cols - 1'b1);
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (cmd_reg.kind)
                    CMD_NOP: ;
                    CMD_CR:  col_next = '0;
                    CMD_SET_CUR:
                    begin
                        row_next = cmd_reg.set_row;
                        col_next = cmd_reg.set_col;
                    end
                    CMD_NEWLINE: state_next = ST_NEXTLINE;
                    CMD_TAB:
                    begin
                        pch_next   = CH_SPACE;
                        cnt_next   = TAB_W'(4) - TAB_W'(col_reg[1:0]);
                        state_next = ST_PRINT;
                    end
                    CMD_PRINT:
                    begin
                        pch_next   = cmd_reg.ch;
                        cnt_next   = TAB_W'(1);
                        state_next = ST_PRINT;
                    end
                    CMD_BS:
                    begin
                        if (col_reg != '0)
                        begin
                            col_next  = col_reg - 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = ADDR_W'(cur_addr - 1'b1);
                        end
                    end
                    CMD_DRAW:
                    begin
                        if (cmd_reg.hit)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cmd_reg.addr;
                            mem_wdata = make_cell(cmd_reg.ch, cmd_reg.fg, cmd_reg.bg);
                        end
                    end
                    CMD_CLS:
                    begin
                        row_next       = '0;
                        col_next       = '0;
                        fill_addr_next = '0;
                        fill_end_next  = geom.cells;
                        state_next     = ST_FILL;
                    end
                    CMD_CLR_LINE:
                    begin
                        if (cmd_reg.hit)
                        begin
                            fill_addr_next = CNT_W'(cmd_reg.addr);
                            fill_end_next  = CNT_W'(cmd_reg.addr) + CNT_W'(geom.cols);
                            state_next     = ST_FILL;
                        end
                    end
                    CMD_READ:
                    begin
                        if (cmd_reg.hit)
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    default: ;
                endcase
            end
            ST_PRINT:
            begin
                mem_we    = 1'b1;
                mem_wdata = make_cell(pch_reg, geom.fg, geom.bg);
                cnt_next  = cnt_reg - 1'b1;
                if (col_inc >= geom.cols)
                    state_next = ST_NEXTLINE;
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = (cnt_reg == TAB_W'(1)) ? ST_DONE : ST_PRINT;
                end
            end
            ST_NEXTLINE:
            begin
                col_next = '0;
                if (ROWS_W'(row_reg) + 1'b1 >= geom.rows)
                begin
                    if (geom.rows == ROWS_W'(1))
                    begin
                        fill_addr_next = CNT_W'(geom.last_base);
                        fill_end_next  = geom.cells;
                        state_next     = ST_FILL;
                    end
                    else
                    begin
                        cp_addr_next = CNT_W'(geom.cols);
                        cp_pend_next = 1'b0;
                        state_next   = ST_COPY;
                    end
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = (cnt_reg != '0) ? ST_PRINT : ST_DONE;
                end
            end
            ST_COPY:
            begin
                if (cp_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cp_dst_reg;
                    mem_wdata = rd_data_reg;
                end
                if (cp_addr_reg < geom.cells)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = cp_addr_reg[ADDR_W-1:0];
                    cp_addr_next = cp_addr_reg + 1'b1;
                    cp_pend_next = 1'b1;
                    cp_dst_next  = ADDR_W'(cp_addr_reg - CNT_W'(geom.cols));
                end
                else
                begin
                    cp_pend_next = 1'b0;
                    if (!cp_pend_reg)
                    begin
                        fill_addr_next = CNT_W'(geom.last_base);
                        fill_end_next  = geom.cells;
                        state_next     = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                mem_we         = 1'b1;
                mem_waddr      = fill_addr_reg[ADDR_W-1:0];
                fill_addr_next = fill_addr_reg + 1'b1;
                if (fill_addr_next >= fill_end_reg)
                    state_next = (cnt_reg != '0) ? ST_PRINT : ST_DONE;
            end
            ST_READ:
            begin
                value_next = rd_data_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    out_col_next   = col_reg;
                    out_value_next = value_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            fill_addr_reg <= '0;
            cp_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            fill_addr_reg <= fill_addr_next;
            cp_pend_reg   <= cp_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pch_reg       <= pch_next;
        value_reg     <= value_next;
        fill_end_reg  <= fill_end_next;
        cp_addr_reg   <= cp_addr_next;
        cp_dst_reg    <= cp_dst_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_value_reg <= out_value_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

endmodule

>>> rtl/text_mode_terminal.sv
// Text-mode terminal: request decoder, command queue and executor with screen memory.
// A simple word runs the executor's idle, execute and done states; a printable character,
// a read or a line feed adds a state, a tab a print step per space, clear line and clear
// screen a fill step per cell, a scroll a one-row-up copy plus a last-row fill (fill only
// on a one-row screen); the screen walk is one cell per cycle, the queue decouples input.
// Reset: cursor home, 25x80 white on black; the memory zeroing pass takes no request word.
module text_mode_terminal import tmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tmt_req_if.sink   req,
    tmt_rsp_if.source rsp,
    tmt_cfg_if.sink   cfg
);

    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;
    logic [3:0]        fg_reg;
    logic [3:0]        bg_reg;
    term_cfg_t         geom;
    logic              wr;

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    cmd_t              q_in;
    cmd_t              q_out;
    logic              wiping;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
            fg_reg   <= FG_RESET;
            bg_reg   <= BG_RESET;
        end
        else if (wr)
        begin
            case (cfg.index)
                REG_ROWS: rows_reg <= cfg.data[ROWS_W-1:0];
                REG_COLS: cols_reg <= cfg.data[COLS_W-1:0];
                REG_FG:   fg_reg   <= cfg.data[3:0];
                REG_BG:   bg_reg   <= cfg.data[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        geom.rows = (rows_reg == '0) ? ROWS_W'(1) :
                    (rows_reg > ROWS_MAX) ? ROWS_MAX : rows_reg;
        geom.cols = (cols_reg == '0) ? COLS_W'(1) :
                    (cols_reg > COLS_MAX) ? COLS_MAX : cols_reg;
        geom.cells     = CNT_W'(geom.rows) * CNT_W'(geom.cols);
        geom.last_base = ADDR_W'(geom.cells - CNT_W'(geom.cols));
        geom.fg        = fg_reg;
        geom.bg        = bg_reg;
    end

    tmt_front u_front
    (
        .req    (req),
        .geom   (geom),
        .wiping (wiping),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    tmt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    tmt_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .geom    (geom),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .wiping  (wiping),
        .rsp     (rsp)
    );

endmodule

>>> sim/tmt_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the text-mode terminal: tracks register writes and request words,
// predicts the cursor and cell readback of each word and compares every response.
// Depends on tmt_pkg and the channel interfaces of tmt_ifs.sv.
module tmt_checker import tmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tmt_req_if   req,
    tmt_rsp_if   rsp,
    tmt_cfg_if   cfg,
    output int   fail_count,
    output int   outstanding
);

    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] value;
    } term_view_t;

    logic [CELL_W-1:0] screen_shadow [MEM_DEPTH];
    int unsigned       cursor_row;
    int unsigned       cursor_col;
    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;
    logic [3:0]        fg_reg;
    logic [3:0]        bg_reg;
    term_view_t        pending_views [$];

    function automatic int unsigned screen_rows();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > MAX_ROWS)
            return MAX_ROWS;
        return rows_reg;
    endfunction

    function automatic int unsigned screen_cols();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > MAX_COLS)
            return MAX_COLS;
        return cols_reg;
    endfunction

    task automatic store_cell(int unsigned r, int unsigned c, logic [CELL_W-1:0] v);
        int unsigned idx;
        idx = r * screen_cols() + c;
        if (idx < MEM_DEPTH)
            screen_shadow[idx] = v;
    endtask

    task automatic blank_row(int unsigned r);
        for (int unsigned c = 0; c < screen_cols(); c++)
            store_cell(r, c, {bg_reg, fg_reg, CH_SPACE});
    endtask

    task automatic scroll_up();
        int unsigned nr;
        int unsigned nc;
        nr = screen_rows();
        nc = screen_cols();
        for (int unsigned r = 1; r < nr; r++)
            for (int unsigned c = 0; c < nc; c++)
                screen_shadow[(r - 1) * nc + c] = screen_shadow[r * nc + c];
        blank_row(nr - 1);
        if (cursor_row > 0)
            cursor_row--;
    endtask

    task automatic new_line();
        cursor_col = 0;
        cursor_row++;
        if (cursor_row >= screen_rows())
            scroll_up();
    endtask

    task automatic print_glyph(logic [7:0] ch);
        store_cell(cursor_row, cursor_col, {bg_reg, fg_reg, ch});
        cursor_col++;
        if (cursor_col >= screen_cols())
            new_line();
    endtask

    task automatic type_char(logic [7:0] ch);
        int unsigned n;
        if (ch == CH_LF)
            new_line();
        else if (ch == CH_CR)
            cursor_col = 0;
        else if (ch == CH_TAB)
        begin
            n = 4 - (cursor_col % 4);
            repeat (n) print_glyph(CH_SPACE);
        end
        else if (ch == CH_BS)
        begin
            if (cursor_col > 0)
            begin
                cursor_col--;
                store_cell(cursor_row, cursor_col, {bg_reg, fg_reg, CH_SPACE});
            end
        end
        else if (ch >= CH_SPACE)
            print_glyph(ch);
    endtask

    task automatic predict_word(input logic [2:0] act, input logic [7:0] ch,
                                input logic [ROW_W-1:0] tr, input logic [COL_W-1:0] tc,
                                input logic [3:0] fg, input logic [3:0] bg,
                                output term_view_t view);
        int unsigned nr;
        int unsigned nc;
        logic [CELL_W-1:0] value;
        nr = screen_rows();
        nc = screen_cols();
        value = '0;
        // a shrunk screen pulls the cursor back inside first
        if (cursor_row >= nr)
            cursor_row = nr - 1;
        if (cursor_col >= nc)
            cursor_col = nc - 1;
        case (act)
            ACT_PUT_CHAR: type_char(ch);
            ACT_SET_CUR:
            begin
                cursor_row = (tr >= nr) ? nr - 1 : tr;
                cursor_col = (tc >= nc) ? nc - 1 : tc;
            end
            ACT_DRAW_AT:
            begin
                if (tr < nr && tc < nc)
                    store_cell(tr, tc, {bg, fg, ch});
            end
            ACT_CLS:
            begin
                for (int unsigned r = 0; r < nr; r++)
                    blank_row(r);
                cursor_row = 0;
                cursor_col = 0;
            end
            ACT_CLR_LINE:
            begin
                if (tr < nr)
                    blank_row(tr);
            end
            ACT_READ:
            begin
                if (tr < nr && tc < nc && tr * nc + tc < MEM_DEPTH)
                    value = screen_shadow[tr * nc + tc];
            end
            default: ;
        endcase
        view.row   = ROW_W'(cursor_row);
        view.col   = COL_W'(cursor_col);
        view.value = value;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        term_view_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_DEPTH; i++)
                screen_shadow[i] = '0;
            cursor_row = 0;
            cursor_col = 0;
            rows_reg   = ROWS_RESET;
            cols_reg   = COLS_RESET;
            fg_reg     = FG_RESET;
            bg_reg     = BG_RESET;
            fail_count = 0;
            pending_views.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_ROWS: rows_reg = cfg.data[ROWS_W-1:0];
                    REG_COLS: cols_reg = cfg.data[COLS_W-1:0];
                    REG_FG:   fg_reg   = cfg.data[3:0];
                    REG_BG:   bg_reg   = cfg.data[3:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                predict_word(req.action, req.char_code, req.target_row, req.target_col,
                             req.cell_fg, req.cell_bg, want);
                pending_views.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (pending_views.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none actual row %0d col %0d cell 0x%0h",
                             $time, rsp.cur_row, rsp.cur_col, rsp.cell_value);
                    fail_count++;
                end
                else
                begin
                    want = pending_views.pop_front();
                    check_field("cur_row", want.row, rsp.cur_row);
                    check_field("cur_col", want.col, rsp.cur_col);
                    check_field("cell_value", want.value, rsp.cell_value);
                end
            end
        end
        outstanding <= pending_views.size();
    end

endmodule

>>> sim/tb_text_mode_terminal.sv
`timescale 1ns / 1ps
// Top of the text-mode terminal testbench: clock, reset, directed and random request
// words in bursts, register writes between phases and response back-pressure.
// Depends on tmt_pkg, tmt_ifs.sv, text_mode_terminal and tmt_checker.
module tb_text_mode_terminal import tmt_pkg::*;
();

    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;
    localparam logic [7:0] CH_NUL      = 8'd0;
    localparam logic [7:0] CH_US       = 8'd31;
    localparam int         CYCLE_LIMIT = 3_000_000;

    logic              clk;
    logic              rst_n;
    int                fail_count;
    int                outstanding;
    int                cycle_count;
    int                burst_left;
    int                stall_mode;
    int                stall_left;
    logic [ROWS_W-1:0] rows_set;
    logic [COLS_W-1:0] cols_set;

    tmt_req_if req_ch ();
    tmt_rsp_if rsp_ch ();
    tmt_cfg_if cfg_ch ();

    text_mode_terminal dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    tmt_checker scoreboard
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // response back-pressure: free flow, coin flips, one in four, long stalls
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= (stall_left % 4 == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_text_mode_terminal NOT OK");
        $finish;
    end

    function automatic int unsigned view_rows();
        if (rows_set == 0)
            return 1;
        return (rows_set > MAX_ROWS) ? MAX_ROWS : rows_set;
    endfunction

    function automatic int unsigned view_cols();
        if (cols_set == 0)
            return 1;
        return (cols_set > MAX_COLS) ? MAX_COLS : cols_set;
    endfunction

    task automatic send_word(logic [2:0] act, logic [7:0] ch, logic [ROW_W-1:0] r,
                             logic [COL_W-1:0] c, logic [3:0] fg, logic [3:0] bg);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.char_code  <= ch;
        req_ch.target_row <= r;
        req_ch.target_col <= c;
        req_ch.cell_fg    <= fg;
        req_ch.cell_bg    <= bg;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_regs(logic [ROWS_W-1:0] rows, logic [COLS_W-1:0] cols,
                              logic [3:0] fg, logic [3:0] bg);
        logic [CFG_DAT_W-1:0] vals [4];
        vals[REG_ROWS] = CFG_DAT_W'(rows);
        vals[REG_COLS] = CFG_DAT_W'(cols);
        vals[REG_FG]   = CFG_DAT_W'(fg);
        vals[REG_BG]   = CFG_DAT_W'(bg);
        for (int i = 0; i < 4; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= CFG_IDX_W'(i);
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        rows_set = rows;
        cols_set = cols;
    endtask

    task automatic random_word();
        int unsigned      pick;
        int unsigned      sub;
        logic [2:0]       act;
        logic [7:0]       ch;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        ch = 8'($urandom);
        r  = ROW_W'($urandom);
        c  = COL_W'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            r = ROW_W'($urandom_range(0, view_rows() - 1));
            c = COL_W'($urandom_range(0, view_cols() - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 42)
        begin
            act = ACT_PUT_CHAR;
            sub = $urandom_range(0, 99);
            if (sub < 62)
                ch = 8'($urandom_range(32, 255));
            else if (sub < 72)
                ch = CH_LF;
            else if (sub < 78)
                ch = CH_CR;
            else if (sub < 86)
                ch = CH_TAB;
            else if (sub < 94)
                ch = CH_BS;
            else
                ch = 8'($urandom_range(0, 31));
        end
        else if (pick < 50)
            act = ACT_SET_CUR;
        else if (pick < 62)
            act = ACT_DRAW_AT;
        else if (pick < 65)
            act = ACT_CLS;
        else if (pick < 70)
            act = ACT_CLR_LINE;
        else if (pick < 96)
            act = ACT_READ;
        else
            act = pick[0] ? ACT_SPARE_A : ACT_SPARE_B;
        send_word(act, ch, r, c, 4'($urandom), 4'($urandom));
    endtask

    task automatic run_phase(logic [ROWS_W-1:0] rows, logic [COLS_W-1:0] cols,
                             logic [3:0] fg, logic [3:0] bg, int count);
        settle();
        write_regs(rows, cols, fg, bg);
        repeat (count) random_word();
    endtask

    // reset geometry 25x80, white on black
    task automatic directed_words();
        send_word(ACT_READ,     CH_NUL,   5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_PUT_CHAR, 8'h41,    5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_PUT_CHAR, 8'hFF,    5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_PUT_CHAR, CH_SPACE, 5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_PUT_CHAR, CH_TAB,   5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_PUT_CHAR, CH_BS,    5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_READ,     CH_NUL,   5'd0,  7'd1,   4'd0,  4'd0);
        send_word(ACT_SET_CUR,  CH_NUL,   5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_PUT_CHAR, CH_BS,    5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_PUT_CHAR, CH_NUL,   5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_PUT_CHAR, CH_US,    5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_PUT_CHAR, CH_LF,    5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_PUT_CHAR, CH_CR,    5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_SET_CUR,  CH_NUL,   5'd31, 7'd127, 4'd0,  4'd0);
        send_word(ACT_PUT_CHAR, 8'h5A,    5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_DRAW_AT,  8'hFF,    5'd24, 7'd79,  4'd15, 4'd15);
        send_word(ACT_DRAW_AT,  CH_NUL,   5'd25, 7'd0,   4'd15, 4'd15);
        send_word(ACT_DRAW_AT,  8'h5A,    5'd0,  7'd80,  4'd15, 4'd15);
        send_word(ACT_READ,     CH_NUL,   5'd24, 7'd79,  4'd0,  4'd0);
        send_word(ACT_READ,     CH_NUL,   5'd31, 7'd127, 4'd0,  4'd0);
        send_word(ACT_CLR_LINE, CH_NUL,   5'd23, 7'd0,   4'd0,  4'd0);
        send_word(ACT_CLR_LINE, CH_NUL,   5'd31, 7'd0,   4'd0,  4'd0);
        send_word(ACT_READ,     CH_NUL,   5'd23, 7'd5,   4'd0,  4'd0);
        send_word(ACT_SPARE_A,  8'hFF,    5'd31, 7'd127, 4'd15, 4'd15);
        send_word(ACT_SPARE_B,  CH_NUL,   5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_CLS,      CH_NUL,   5'd0,  7'd0,   4'd0,  4'd0);
        send_word(ACT_READ,     CH_NUL,   5'd10, 7'd10,  4'd0,  4'd0);
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= ACT_PUT_CHAR;
        req_ch.char_code  <= '0;
        req_ch.target_row <= '0;
        req_ch.target_col <= '0;
        req_ch.cell_fg    <= '0;
        req_ch.cell_bg    <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_ROWS;
        cfg_ch.data       <= '0;
        rows_set   = ROWS_RESET;
        cols_set   = COLS_RESET;
        burst_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        directed_words();
        run_phase(6'd4,  8'd8,   4'd3,  4'd12, 110);
        run_phase(6'd1,  8'd1,   4'd0,  4'd15, 60);
        run_phase(6'd0,  8'd0,   4'd15, 4'd0,  40);
        run_phase(6'd32, 8'd1,   4'd9,  4'd6,  60);
        run_phase(6'd1,  8'd128, 4'd5,  4'd10, 60);
        run_phase(6'd63, 8'd255, 4'd7,  4'd2,  25);
        run_phase(6'd6,  8'd13,  4'($urandom), 4'($urandom), 150);
        run_phase(6'd32, 8'd128, 4'd15, 4'd15, 25);
        run_phase(6'd3,  8'd5,   4'($urandom), 4'($urandom), 170);

        settle();
        repeat (64) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_text_mode_terminal OK");
        else
            $display("tb_text_mode_terminal NOT OK");
        $finish;
    end

endmodule
